### design/plar_pkg.sv
// Package for the polyline arc-length resampler.
// Holds fixed widths, the reset spacing and shared flag types. No dependencies.
package plar_pkg;

  // Spacing register width and reset value (micrometres)
  localparam int STEP_W     = 20;
  localparam int STEP_RESET = 1000;

  // Depth of the queue between the front and back halves
  localparam int QDEPTH = 2;

  // Per-vertex classification travelling through the queue
  typedef struct packed {
    logic first;
    logic last;
  } vtx_flags_t;

  // Flags attached to each emitted point
  typedef struct packed {
    logic run_last;
    logic trace_end;
    logic capped;
  } res_flags_t;

endpackage

### design/plar_front.sv
// Front half: accepts vertices, keeps the previous vertex and trace state,
// and forms per-axis deltas. Depends on plar_pkg.
module plar_front
  import plar_pkg::*;
#(
  parameter int CW = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] in_vertex_x,
  input  logic signed [CW-1:0] in_vertex_y,
  input  logic signed [CW-1:0] in_vertex_z,
  input  logic                 in_trace_last,
  output logic                 push_valid,
  input  logic                 push_ready,
  output logic [3*CW-1:0]      push_v,
  output logic [3*CW-1:0]      push_prev,
  output logic [3*CW-1:0]      push_ad,
  output logic [2:0]           push_neg,
  output vtx_flags_t           push_flags
);

  logic [CW-1:0] prev_r [3];
  logic [CW-1:0] prev_nxt [3];
  logic          in_trace_r, in_trace_nxt;
  logic [CW-1:0] v [3];
  logic [CW:0]   d [3];
  logic [CW:0]   dn [3];
  logic          acc;

  assign v[0] = in_vertex_x;
  assign v[1] = in_vertex_y;
  assign v[2] = in_vertex_z;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign acc        = in_valid && push_ready;

  // Per-axis delta, magnitude and sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i]  = {v[i][CW-1], v[i]} - {prev_r[i][CW-1], prev_r[i]};
      dn[i] = -d[i];
      push_neg[i] = d[i][CW];
      push_ad[i*CW +: CW]   = d[i][CW] ? dn[i][CW-1:0] : d[i][CW-1:0];
      push_v[i*CW +: CW]    = v[i];
      push_prev[i*CW +: CW] = prev_r[i];
    end
  end

  assign push_flags.first = !in_trace_r;
  assign push_flags.last  = in_trace_last;

  // Vertex history and trace state
  always_comb begin
    in_trace_nxt = in_trace_r;
    for (int i = 0; i < 3; i++) prev_nxt[i] = prev_r[i];
    if (acc) begin
      in_trace_nxt = !in_trace_last;
      for (int i = 0; i < 3; i++) prev_nxt[i] = v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_trace_r <= 1'b0;
      for (int i = 0; i < 3; i++) prev_r[i] <= '0;
    end else begin
      in_trace_r <= in_trace_nxt;
      for (int i = 0; i < 3; i++) prev_r[i] <= prev_nxt[i];
    end
  end

endmodule

### design/plar_queue.sv
// Small FIFO between the front and back halves.
// Depends on plar_pkg for its depth.
module plar_queue
  import plar_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNW = $clog2(QDEPTH + 1);

  logic [W-1:0]   mem [QDEPTH];
  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           wr, rd;

  assign wr_ready = cnt_r != CNW'(QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  // Pointer and occupancy update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr) wp_nxt = (wp_r == PW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (rd) rp_nxt = (rp_r == PW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (wr && !rd) cnt_nxt = cnt_r + 1'b1;
    else if (rd && !wr) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### design/plar_back.sv
// Back half: chord length by digit square root, sample count by serial
// division, per-sample interpolation by three divider lanes, output register.
// Depends on plar_pkg.
module plar_back
  import plar_pkg::*;
#(
  parameter int CW   = 24,
  parameter int FB   = 8,
  parameter int MAXR = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [STEP_W-1:0] step_length,
  input  logic              q_valid,
  output logic              q_ready,
  input  logic [3*CW-1:0]   q_v,
  input  logic [3*CW-1:0]   q_prev,
  input  logic [3*CW-1:0]   q_ad,
  input  logic [2:0]        q_neg,
  input  vtx_flags_t        q_flags,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CW-1:0]     out_x,
  output logic [CW-1:0]     out_y,
  output logic [CW-1:0]     out_z,
  output res_flags_t        out_flags
);

  localparam int LW   = CW + FB + 1;              // chord length
  localparam int SQW  = 2 * CW + 2;               // sum of squares
  localparam int RW   = LW + 2;                   // root / sample remainders
  localparam int STW  = STEP_W + FB;              // step in fixed point
  localparam int TW   = ((LW > STW) ? LW : STW) + 1;
  localparam int DW   = STW + 1;
  localparam int IW   = CW + STW;
  localparam int AW   = CW + TW;
  localparam int NW   = AW + 2;
  localparam int KW   = $clog2(MAXR);
  localparam int CTW  = $clog2(TW + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_SQRT = 4'd2;
  localparam logic [3:0] S_LEN  = 4'd3;
  localparam logic [3:0] S_DIVN = 4'd4;
  localparam logic [3:0] S_NCAP = 4'd5;
  localparam logic [3:0] S_PRE  = 4'd6;
  localparam logic [3:0] S_SLD  = 4'd7;
  localparam logic [3:0] S_SDIV = 4'd8;
  localparam logic [3:0] S_SFIN = 4'd9;
  localparam logic [3:0] S_EMIT = 4'd10;
  localparam logic [3:0] S_TAIL = 4'd11;

  localparam logic [1:0] K_SAMP  = 2'd0;
  localparam logic [1:0] K_FIRST = 2'd1;
  localparam logic [1:0] K_TRAIL = 2'd2;

  logic [3:0]      state_r, state_nxt;
  logic [CTW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]   v_r [3], v_nxt [3];
  logic [CW-1:0]   prev_r [3], prev_nxt [3];
  logic [CW-1:0]   ad_r [3], ad_nxt [3];
  logic [2:0]      neg_r, neg_nxt;
  logic            last_r, last_nxt;
  logic [SQW-1:0]  s_r, s_nxt;
  logic [2*LW-1:0] rad_r, rad_nxt;
  logic [LW-1:0]   root_r, root_nxt;
  logic [RW-1:0]   srem_r, srem_nxt;
  logic [TW-1:0]   tot_r, tot_nxt;
  logic [TW-1:0]   dq_r, dq_nxt;
  logic [DW-1:0]   drem_r, drem_nxt;
  logic [STW-1:0]  dist_r, dist_nxt;
  logic [STW-1:0]  al0_r, al0_nxt;
  logic [KW-1:0]   n_r, n_nxt, k_r, k_nxt;
  logic            capf_r, capf_nxt;
  logic [IW-1:0]   inc_r [3], inc_nxt [3];
  logic [AW-1:0]   acc_r [3], acc_nxt [3];
  logic [RW-1:0]   qrem_r [3], qrem_nxt [3];
  logic [CW-1:0]   nlo_r [3], nlo_nxt [3];
  logic [CW-1:0]   q_r [3], q_nxt [3];
  logic [CW-1:0]   pt_r [3], pt_nxt [3];
  logic [CW-1:0]   lem_r [3], lem_nxt [3];
  logic [1:0]      kind_r, kind_nxt;
  logic            ov_r, ov_nxt;
  logic [CW-1:0]   o_r [3], o_nxt [3];
  res_flags_t      of_r, of_nxt;

  // Shared datapath terms
  logic [STEP_W-1:0] step_eff;
  logic [STW-1:0]    stp, s0;
  logic [1:0]        lane;
  logic [2*CW-1:0]   sq;
  logic [IW-1:0]     prod;
  logic [RW+1:0]     rem2, trial;
  logic [DW:0]       dr2;
  logic [NW-1:0]     num [3];
  logic [RW:0]       qr2 [3];
  logic [RW:0]       dvs;
  logic [CW-1:0]     qs;
  logic              fin, trail, slot;
  res_flags_t        fl;

  assign step_eff = (step_length == '0) ? STEP_W'(1) : step_length;
  assign stp      = STW'(step_eff) << FB;
  assign s0       = (dist_r > stp) ? stp : dist_r;
  assign lane     = (cnt_r < CTW'(3)) ? cnt_r[1:0] : 2'(cnt_r - CTW'(3));
  assign sq       = ad_r[lane] * ad_r[lane];
  assign prod     = ad_r[lane] * ((cnt_r < CTW'(3)) ? stp : al0_r);
  assign rem2     = {srem_r, rad_r[2*LW-1 -: 2]};
  assign trial    = (RW+2)'({root_r, 2'b01});
  assign dr2      = {drem_r, tot_r[TW-1]};
  assign dvs      = (RW+1)'({root_r, 1'b0});
  assign slot     = !ov_r || out_ready;
  assign q_ready  = state_r == S_IDLE;

  // Flags for the point waiting in pt_r
  always_comb begin
    fin   = k_r == (n_r - 1'b1);
    trail = last_r && ((pt_r[0] != v_r[0]) || (pt_r[1] != v_r[1]) || (pt_r[2] != v_r[2]));
    fl.capped = capf_r;
    case (kind_r)
      K_SAMP: begin
        fl.run_last  = fin && !trail;
        fl.trace_end = fin && last_r && !trail;
      end
      K_FIRST: begin
        fl.run_last  = 1'b1;
        fl.trace_end = last_r;
      end
      default: begin
        fl.run_last  = 1'b1;
        fl.trace_end = 1'b1;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    last_nxt  = last_r;
    s_nxt     = s_r;
    rad_nxt   = rad_r;
    root_nxt  = root_r;
    srem_nxt  = srem_r;
    tot_nxt   = tot_r;
    dq_nxt    = dq_r;
    drem_nxt  = drem_r;
    dist_nxt  = dist_r;
    al0_nxt   = al0_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    capf_nxt  = capf_r;
    kind_nxt  = kind_r;
    ov_nxt    = ov_r;
    of_nxt    = of_r;
    qs        = '0;
    for (int i = 0; i < 3; i++) begin
      v_nxt[i]    = v_r[i];
      prev_nxt[i] = prev_r[i];
      ad_nxt[i]   = ad_r[i];
      inc_nxt[i]  = inc_r[i];
      acc_nxt[i]  = acc_r[i];
      qrem_nxt[i] = qrem_r[i];
      nlo_nxt[i]  = nlo_r[i];
      q_nxt[i]    = q_r[i];
      pt_nxt[i]   = pt_r[i];
      lem_nxt[i]  = lem_r[i];
      o_nxt[i]    = o_r[i];
      num[i]      = (NW'(acc_r[i]) << 1) + NW'(root_r);
      qr2[i]      = {qrem_r[i], nlo_r[i][CW-1]};
    end

    // Output register drains independently
    if (ov_r && out_ready) ov_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          for (int i = 0; i < 3; i++) begin
            v_nxt[i]    = q_v[i*CW +: CW];
            prev_nxt[i] = q_prev[i*CW +: CW];
            ad_nxt[i]   = q_ad[i*CW +: CW];
          end
          neg_nxt  = q_neg;
          last_nxt = q_flags.last;
          capf_nxt = 1'b0;
          cnt_nxt  = '0;
          s_nxt    = '0;
          if (q_flags.first) begin
            for (int i = 0; i < 3; i++) pt_nxt[i] = q_v[i*CW +: CW];
            dist_nxt  = '0;
            kind_nxt  = K_FIRST;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_SQ;
          end
        end
      end
      // Sum of squares, one axis a cycle
      S_SQ: begin
        s_nxt   = s_r + SQW'(sq);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CTW'(2)) begin
          rad_nxt   = (2*LW)'(s_nxt) << (2*FB);
          root_nxt  = '0;
          srem_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end
      end
      // Digit-by-digit square root, one result bit a cycle
      S_SQRT: begin
        rad_nxt = rad_r << 2;
        if (rem2 >= trial) begin
          srem_nxt = RW'(rem2 - trial);
          root_nxt = {root_r[LW-2:0], 1'b1};
        end else begin
          srem_nxt = RW'(rem2);
          root_nxt = {root_r[LW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CTW'(LW - 1)) state_nxt = S_LEN;
      end
      S_LEN: begin
        if (root_r == '0) begin
          state_nxt = S_TAIL;
        end else begin
          tot_nxt   = TW'(s0) + TW'(root_r);
          dq_nxt    = '0;
          drem_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIVN;
        end
      end
      // Samples on this chord and new carry: total / step
      S_DIVN: begin
        tot_nxt = tot_r << 1;
        if (dr2 >= (DW+1)'(stp)) begin
          drem_nxt = DW'(dr2 - (DW+1)'(stp));
          dq_nxt   = {dq_r[TW-2:0], 1'b1};
        end else begin
          drem_nxt = DW'(dr2);
          dq_nxt   = {dq_r[TW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CTW'(TW - 1)) state_nxt = S_NCAP;
      end
      S_NCAP: begin
        al0_nxt  = stp - s0;
        dist_nxt = drem_r[STW-1:0];
        if (dq_r > TW'(MAXR - 1)) begin
          n_nxt    = KW'(MAXR - 1);
          capf_nxt = 1'b1;
        end else begin
          n_nxt = dq_r[KW-1:0];
        end
        k_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = S_PRE;
      end
      // Per-axis increments and first-sample products, one multiply a cycle
      S_PRE: begin
        if (cnt_r < CTW'(3)) inc_nxt[lane] = prod;
        else acc_nxt[lane] = AW'(prod);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CTW'(5)) state_nxt = (n_r == '0) ? S_TAIL : S_SLD;
      end
      S_SLD: begin
        for (int i = 0; i < 3; i++) begin
          qrem_nxt[i] = RW'(num[i] >> CW);
          nlo_nxt[i]  = num[i][CW-1:0];
          q_nxt[i]    = '0;
        end
        cnt_nxt   = '0;
        state_nxt = S_SDIV;
      end
      // Three divider lanes: round(ad * along / len)
      S_SDIV: begin
        for (int i = 0; i < 3; i++) begin
          nlo_nxt[i] = nlo_r[i] << 1;
          if (qr2[i] >= dvs) begin
            qrem_nxt[i] = RW'(qr2[i] - dvs);
            q_nxt[i]    = {q_r[i][CW-2:0], 1'b1};
          end else begin
            qrem_nxt[i] = RW'(qr2[i]);
            q_nxt[i]    = {q_r[i][CW-2:0], 1'b0};
          end
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CTW'(CW - 1)) state_nxt = S_SFIN;
      end
      S_SFIN: begin
        for (int i = 0; i < 3; i++) begin
          qs        = neg_r[i] ? (-q_r[i]) : q_r[i];
          pt_nxt[i] = prev_r[i] + qs;
        end
        kind_nxt  = K_SAMP;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot) begin
          ov_nxt = 1'b1;
          of_nxt = fl;
          for (int i = 0; i < 3; i++) begin
            o_nxt[i]   = pt_r[i];
            lem_nxt[i] = pt_r[i];
          end
          if (kind_r == K_SAMP && !fin) begin
            k_nxt = k_r + 1'b1;
            for (int i = 0; i < 3; i++) acc_nxt[i] = acc_r[i] + AW'(inc_r[i]);
            state_nxt = S_SLD;
          end else if (kind_r == K_TRAIL) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_TAIL;
          end
        end
      end
      // Append the end vertex when it was not just emitted
      S_TAIL: begin
        if (last_r && ((lem_r[0] != v_r[0]) || (lem_r[1] != v_r[1]) ||
                       (lem_r[2] != v_r[2]))) begin
          for (int i = 0; i < 3; i++) pt_nxt[i] = v_r[i];
          kind_nxt  = K_TRAIL;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = ov_r;
  assign out_x     = o_r[0];
  assign out_y     = o_r[1];
  assign out_z     = o_r[2];
  assign out_flags = of_r;

  // Control and carried state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      dist_r  <= '0;
      for (int i = 0; i < 3; i++) lem_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      dist_r  <= dist_nxt;
      for (int i = 0; i < 3; i++) lem_r[i] <= lem_nxt[i];
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    last_r <= last_nxt;
    s_r    <= s_nxt;
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    srem_r <= srem_nxt;
    tot_r  <= tot_nxt;
    dq_r   <= dq_nxt;
    drem_r <= drem_nxt;
    al0_r  <= al0_nxt;
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    capf_r <= capf_nxt;
    kind_r <= kind_nxt;
    of_r   <= of_nxt;
    for (int i = 0; i < 3; i++) begin
      v_r[i]    <= v_nxt[i];
      prev_r[i] <= prev_nxt[i];
      ad_r[i]   <= ad_nxt[i];
      inc_r[i]  <= inc_nxt[i];
      acc_r[i]  <= acc_nxt[i];
      qrem_r[i] <= qrem_nxt[i];
      nlo_r[i]  <= nlo_nxt[i];
      q_r[i]    <= q_nxt[i];
      pt_r[i]   <= pt_nxt[i];
      o_r[i]    <= o_nxt[i];
    end
  end

endmodule

### design/polyline_arc_length_resampler_core.sv
// Polyline arc-length resampler, top level.
// Depends on plar_pkg, plar_front, plar_queue and plar_back.
//
// Vertices enter on the in_ channel (valid/ready); resampled points leave on
// the out_ channel (valid/ready), each transaction one point with flags
// run_last (last point of this vertex), trace_end and capped. The cfg_
// channel writes step_length and is always ready; the user must write it only
// while the block is idle, which the block itself does not enforce. A zero step
// acts as one micrometre. A new trace's first vertex passes through the queue
// and the emit state into the output register. A later vertex runs a sum of
// squares, the bit-serial root, a serial division for the sample count and
// setup, then a serial division in three divider lanes per emitted sample, all
// in the back half; two vertices can wait in the queue.
// Reset clears the trace state, the carried distance, the last emitted point
// and the output register, and sets step_length to 1000. When the receiver
// stalls, the finished point holds in the output register, the back half
// waits, and the queue then fills and drops in_ready.
module polyline_arc_length_resampler_core
  import plar_pkg::*;
#(
  parameter int COORD_BITS  = 24,
  parameter int FRAC_BITS   = 8,
  parameter int MAX_RESULTS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [STEP_W-1:0]            cfg_step_length,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_vertex_x,
  input  logic signed [COORD_BITS-1:0] in_vertex_y,
  input  logic signed [COORD_BITS-1:0] in_vertex_z,
  input  logic                         in_trace_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_sample_x,
  output logic signed [COORD_BITS-1:0] out_sample_y,
  output logic signed [COORD_BITS-1:0] out_sample_z,
  output logic                         out_run_last,
  output logic                         out_trace_end,
  output logic                         out_capped
);

  localparam int CW = COORD_BITS;
  localparam int EW = 9 * CW + 3 + $bits(vtx_flags_t);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              pv, pr, qv, qr;
  logic [3*CW-1:0]   p_v, p_prev, p_ad, q_v, q_prev, q_ad;
  logic [2:0]        p_neg, q_neg;
  vtx_flags_t        p_fl, q_fl;
  logic [EW-1:0]     wr_data, rd_data;
  logic [CW-1:0]     ox, oy, oz;
  res_flags_t        ofl;

  // Spacing register
  assign cfg_ready = 1'b1;
  assign step_nxt  = cfg_valid ? cfg_step_length : step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) step_r <= STEP_W'(STEP_RESET);
    else step_r <= step_nxt;
  end

  plar_front #(.CW(CW)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_vertex_x  (in_vertex_x),
    .in_vertex_y  (in_vertex_y),
    .in_vertex_z  (in_vertex_z),
    .in_trace_last(in_trace_last),
    .push_valid   (pv),
    .push_ready   (pr),
    .push_v       (p_v),
    .push_prev    (p_prev),
    .push_ad      (p_ad),
    .push_neg     (p_neg),
    .push_flags   (p_fl)
  );

  assign wr_data = {p_v, p_prev, p_ad, p_neg, p_fl};
  assign {q_v, q_prev, q_ad, q_neg, q_fl} = rd_data;

  plar_queue #(.W(EW)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(pv),
    .wr_ready(pr),
    .wr_data (wr_data),
    .rd_valid(qv),
    .rd_ready(qr),
    .rd_data (rd_data)
  );

  plar_back #(.CW(CW), .FB(FRAC_BITS), .MAXR(MAX_RESULTS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_length(step_r),
    .q_valid    (qv),
    .q_ready    (qr),
    .q_v        (q_v),
    .q_prev     (q_prev),
    .q_ad       (q_ad),
    .q_neg      (q_neg),
    .q_flags    (q_fl),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (ox),
    .out_y      (oy),
    .out_z      (oz),
    .out_flags  (ofl)
  );

  assign out_sample_x  = ox;
  assign out_sample_y  = oy;
  assign out_sample_z  = oz;
  assign out_run_last  = ofl.run_last;
  assign out_trace_end = ofl.trace_end;
  assign out_capped    = ofl.capped;

endmodule

### tb/polyline_arc_length_resampler_core_tb.sv
// Self-checking testbench for polyline_arc_length_resampler_core.
// Depends on plar_pkg and the core; predicts resampled points in a scoreboard class
// and checks every output transaction in order, with random idling on both sides.
`timescale 1ns / 1ps

module polyline_arc_length_resampler_core_tb;
  import plar_pkg::*;

  localparam int CW = 24;
  localparam int FB = 8;
  localparam int MAXR = 64;
  localparam int N_RANDOM = 330;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic run_last;
    logic trace_end;
    logic capped;
  } point_t;

  // Resampler predictor and ordered store of expected points
  class point_scoreboard;
    longint prev_v[3];
    longint last_pt[3];
    longint carry;
    bit in_trace;
    longint step;
    point_t pending[$];
    int mismatches;

    function void reset_state();
      for (int j = 0; j < 3; j++) begin
        prev_v[j] = 0;
        last_pt[j] = 0;
      end
      carry = 0;
      in_trace = 0;
      step = STEP_RESET;
      pending.delete();
      mismatches = 0;
    endfunction

    function void set_step(longint s);
      step = s;
    endfunction

    // Integer square root of a 128-bit value, bit by bit
    function longint unsigned isqrt(logic [127:0] n);
      logic [63:0] r;
      logic [63:0] t;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if ({64'd0, t} * {64'd0, t} <= n) r = t;
      end
      return r;
    endfunction

    // Note an accepted vertex and queue the points it should produce
    function void note_vertex(longint vx, longint vy, longint vz, bit last);
      longint v[3];
      longint d[3];
      longint ad[3];
      longint p[3];
      logic [127:0] sq;
      logic [127:0] num;
      longint len, stp, s0, total, n, along, q;
      bit capflag;
      point_t pts[$];
      point_t e;
      // coordinates wrap to the port width
      v[0] = longint'($signed(CW'(vx)));
      v[1] = longint'($signed(CW'(vy)));
      v[2] = longint'($signed(CW'(vz)));
      capflag = 0;
      if (!in_trace) begin
        e.x = CW'(v[0]); e.y = CW'(v[1]); e.z = CW'(v[2]);
        pts = {pts, e};
        for (int j = 0; j < 3; j++) last_pt[j] = v[j];
        carry = 0;
        in_trace = 1;
      end else begin
        sq = 0;
        for (int j = 0; j < 3; j++) begin
          d[j] = v[j] - prev_v[j];
          ad[j] = d[j] < 0 ? -d[j] : d[j];
          sq += 128'(ad[j]) * 128'(ad[j]);
        end
        len = isqrt(sq << (2 * FB));
        if (len != 0) begin
          stp = (step == 0 ? 1 : step) << FB;
          s0 = carry > stp ? stp : carry;
          total = s0 + len;
          n = total / stp;
          if (n > MAXR - 1) begin
            n = MAXR - 1;
            capflag = 1;
          end
          for (longint k = 0; k < n; k++) begin
            along = (stp - s0) + k * stp;
            for (int j = 0; j < 3; j++) begin
              num = (128'(ad[j]) * 128'(along)) * 2 + 128'(len);
              q = longint'(num / (128'(len) * 2));
              p[j] = prev_v[j] + (d[j] < 0 ? -q : q);
            end
            e.x = CW'(p[0]); e.y = CW'(p[1]); e.z = CW'(p[2]);
            pts = {pts, e};
            for (int j = 0; j < 3; j++) last_pt[j] = p[j];
          end
          carry = total % stp;
        end
      end
      for (int j = 0; j < 3; j++) prev_v[j] = v[j];
      if (last) begin
        if (last_pt[0] != v[0] || last_pt[1] != v[1] || last_pt[2] != v[2]) begin
          e.x = CW'(v[0]); e.y = CW'(v[1]); e.z = CW'(v[2]);
          pts = {pts, e};
          for (int j = 0; j < 3; j++) last_pt[j] = v[j];
        end
        in_trace = 0;
      end
      foreach (pts[k]) begin
        e = pts[k];
        e.run_last = (k == pts.size() - 1);
        e.trace_end = e.run_last && last;
        e.capped = capflag;
        pending = {pending, e};
      end
    endfunction

    // Compare one output transaction against the oldest expectation
    function void check_point(point_t got);
      point_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected point x=%0d y=%0d z=%0d", got.x, got.y, got.z);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch exp x=%0d y=%0d z=%0d rl=%b te=%b cap=%b got x=%0d y=%0d z=%0d rl=%b te=%b cap=%b",
                   want.x, want.y, want.z, want.run_last, want.trace_end, want.capped,
                   got.x, got.y, got.z, got.run_last, got.trace_end, got.capped);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [STEP_W-1:0] cfg_step_length;
  logic in_valid;
  logic in_ready;
  logic signed [CW-1:0] in_vertex_x, in_vertex_y, in_vertex_z;
  logic in_trace_last;
  logic out_valid;
  logic out_ready;
  logic signed [CW-1:0] out_sample_x, out_sample_y, out_sample_z;
  logic out_run_last, out_trace_end, out_capped;

  point_scoreboard sb;
  longint cycles;
  bit hold_off;
  int hold_cycles;

  polyline_arc_length_resampler_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_step_length(cfg_step_length),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_vertex_x(in_vertex_x), .in_vertex_y(in_vertex_y), .in_vertex_z(in_vertex_z),
    .in_trace_last(in_trace_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_sample_x(out_sample_x), .out_sample_y(out_sample_y), .out_sample_z(out_sample_z),
    .out_run_last(out_run_last), .out_trace_end(out_trace_end), .out_capped(out_capped)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested
  initial begin
    point_t got;
    int gap;
    out_ready = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 0;
        repeat (hold_cycles) @(posedge clk);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.x = out_sample_x; got.y = out_sample_y; got.z = out_sample_z;
      got.run_last = out_run_last; got.trace_end = out_trace_end;
      got.capped = out_capped;
      sb.check_point(got);
    end
  end

  // Send one vertex after a random gap (gap skipped in burst mode)
  task automatic send_vertex(longint x, longint y, longint z, bit last, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_vertex_x <= CW'(x); in_vertex_y <= CW'(y); in_vertex_z <= CW'(z);
    in_trace_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_vertex(x, y, z, last);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    // a vertex that yields nothing may still be in flight
    repeat (400) @(posedge clk);
  endtask

  task automatic write_step(longint s);
    cfg_valid <= 1;
    cfg_step_length <= STEP_W'(s);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.set_step(s);
  endtask

  function automatic longint rand_coord();
    return longint'($signed(24'($urandom)));
  endfunction

  // Random trace near a base point with small hops
  task automatic random_trace(int nv, int span);
    longint x, y, z;
    x = longint'($signed(24'($urandom_range(0, 2000000) - 1000000)));
    y = longint'($signed(24'($urandom_range(0, 2000000) - 1000000)));
    z = longint'($signed(24'($urandom_range(0, 2000000) - 1000000)));
    for (int i = 0; i < nv; i++) begin
      if (i > 0 && $urandom_range(0, 9) != 0) begin
        x += longint'($urandom_range(0, 2 * span)) - longint'(span);
        y += longint'($urandom_range(0, 2 * span)) - longint'(span);
        z += longint'($urandom_range(0, 2 * span)) - longint'(span);
      end
      send_vertex(x, y, z, i == nv - 1, 0);
    end
  endtask

  initial begin
    int sent;
    int nv;
    sb = new();
    sb.reset_state();
    hold_off = 0;
    hold_cycles = 0;
    rst_n = 0;
    cfg_valid = 0;
    cfg_step_length = 0;
    in_valid = 0;
    in_vertex_x = 0; in_vertex_y = 0; in_vertex_z = 0;
    in_trace_last = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: reset step, lone vertex, repeated vertex, silent end
    send_vertex(0, 0, 0, 1, 0);
    send_vertex(100, -200, 300, 0, 0);
    send_vertex(100, -200, 300, 0, 0);
    send_vertex(2600, -200, 300, 0, 0);
    send_vertex(2600, -200, 300, 1, 0);
    // Extremes of the coordinates, capped chord
    send_vertex(-8388608, -8388608, -8388608, 0, 0);
    send_vertex(8388607, 8388607, 8388607, 1, 0);
    drain();
    // Step one micrometre: short uncapped chord, then step lowered inside a trace
    write_step(0);
    send_vertex(10, 10, 10, 0, 0);
    send_vertex(13, 14, 10, 0, 0);
    drain();
    write_step(1048575);
    send_vertex(13, 14, 10, 0, 0);
    send_vertex(500000, 0, 0, 0, 0);
    drain();
    write_step(1);
    send_vertex(500005, 0, 0, 1, 0);
    drain();
    write_step(1048575);
    send_vertex(-8388608, 0, 8388607, 0, 0);
    send_vertex(8388607, 0, -8388608, 0, 0);
    send_vertex(8388607, 0, -8388608, 1, 0);
    drain();

    // Fill the block while the receiver holds off
    write_step(700);
    hold_cycles = 1500;
    hold_off = 1;
    send_vertex(0, 0, 0, 0, 1);
    for (int i = 1; i < 6; i++) send_vertex(i * 1500, i * 300, -i * 200, i == 5, 1);
    drain();

    // Random traces across several spacings, mostly small chords
    sent = 0;
    while (sent < N_RANDOM) begin
      if ($urandom_range(0, 4) == 0) begin
        drain();
        case ($urandom_range(0, 3))
          0: write_step($urandom_range(1, 50));
          1: write_step($urandom_range(200, 5000));
          2: write_step($urandom_range(1, 1048575));
          default: write_step(1000);
        endcase
      end
      if ($urandom_range(0, 19) == 0) begin
        send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(0, 1)), 0);
        sent++;
      end else begin
        nv = $urandom_range(1, 8);
        random_trace(nv, (sb.step < 100) ? 200 : 4 * int'(sb.step));
        sent += nv;
      end
    end
    drain();

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
